/* hw/rtl/mwtb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwtb_pkg
// Shared types and constants of the multichannel window/tint blend.
// ----------------------------------------------------------------------------
package mwtb_pkg;

  localparam int unsigned ChannelsDef = 4;
  localparam int unsigned Levels      = 256;
  localparam int unsigned LevelW      = 8;
  localparam int unsigned ChW         = 2;
  localparam int unsigned SampleW     = 32;
  localparam int unsigned CfgW        = 64;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned WinCount    = 4;
  localparam int unsigned TintPairW   = 54;
  localparam int unsigned TintSetW    = 27;
  localparam int unsigned TintW       = 9;
  localparam int unsigned SumW        = 10;
  localparam int unsigned PixelW      = 32;
  localparam int unsigned QueueDepth  = 4;

  localparam logic [SumW-1:0]      SumMax   = 10'd1023;
  localparam logic [LevelW-1:0]    GreyMax  = 8'd255;
  localparam logic [LevelW-1:0]    AlphaOn  = 8'hFF;
  localparam logic [CfgW-1:0]      WinRst   = 64'h0000_0000_00FF_0000;
  localparam logic [TintPairW-1:0] TintRst  = 54'd9024825867763968;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIN0    = 3'd0,
    CFG_WIN1    = 3'd1,
    CFG_WIN2    = 3'd2,
    CFG_WIN3    = 3'd3,
    CFG_TINT_LO = 3'd4,
    CFG_TINT_HI = 3'd5,
    CFG_AVG     = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TABLE  = 1'b1
  } op_e;

  typedef struct packed {
    logic                      opcode;
    logic [ChW-1:0]            channel;
    logic signed [SampleW-1:0] sample_a;
    logic signed [SampleW-1:0] sample_b;
    logic signed [SampleW-1:0] sample_c;
    logic signed [SampleW-1:0] sample_d;
    logic                      last_channel;
    logic [LevelW-1:0]         table_index;
    logic [LevelW-1:0]         table_value;
  } in_item_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel_word;
  } out_item_t;

  typedef struct packed {
    op_e            op;
    logic [ChW-1:0] channel;
    logic           ch_ok;
    logic           last;
  } ctrl_t;

  typedef struct packed {
    ctrl_t                   ctrl;
    logic signed [SampleW-1:0] sample_a;
    logic signed [SampleW:0]   sum_ab;
    logic signed [SampleW:0]   sum_cd;
    logic [LevelW-1:0]         tbl_idx;
    logic [LevelW-1:0]         tbl_val;
  } q_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] lo;
    logic [SampleW-1:0]        scale;
  } win_t;

  typedef struct packed {
    logic [TintW-1:0] blue;
    logic [TintW-1:0] green;
    logic [TintW-1:0] red;
  } tint_t;

  typedef struct packed {
    win_t [WinCount-1:0]  win;
    logic [TintPairW-1:0] tint_lo;
    logic [TintPairW-1:0] tint_hi;
    logic                 avg;
  } cfg_t;

endpackage

/* hw/rtl/mwtb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwtb_in_if / mwtb_out_if
// Valid/ready channels carrying input items and pixel results.
// ----------------------------------------------------------------------------
interface mwtb_in_if;
  logic               valid;
  logic               ready;
  mwtb_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mwtb_out_if;
  logic                valid;
  logic                ready;
  mwtb_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/mwtb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwtb_front
// Takes requests, tags opcode and channel, forms neighbourhood pair sums.
// ----------------------------------------------------------------------------
module mwtb_front #(
  parameter int unsigned Channels = mwtb_pkg::ChannelsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                init_done_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mwtb_pkg::in_item_t  in_item_i,
  input  logic                full_i,
  output logic                push_o,
  output mwtb_pkg::q_item_t   q_item_o
);

  logic              front_v_q;
  mwtb_pkg::q_item_t front_q;
  mwtb_pkg::q_item_t cls;
  logic              take;

  assign push_o     = front_v_q & ~full_i;
  assign in_ready_o = init_done_i & (~front_v_q | ~full_i);
  assign take       = in_valid_i & in_ready_o;
  assign q_item_o   = front_q;

  always_comb begin
    cls.ctrl.op      = mwtb_pkg::op_e'(in_item_i.opcode);
    cls.ctrl.channel = in_item_i.channel;
    cls.ctrl.ch_ok   = (int'(in_item_i.channel) < Channels);
    cls.ctrl.last    = in_item_i.last_channel;
    cls.sample_a     = in_item_i.sample_a;
    cls.sum_ab       = {in_item_i.sample_a[mwtb_pkg::SampleW-1], in_item_i.sample_a}
                     + {in_item_i.sample_b[mwtb_pkg::SampleW-1], in_item_i.sample_b};
    cls.sum_cd       = {in_item_i.sample_c[mwtb_pkg::SampleW-1], in_item_i.sample_c}
                     + {in_item_i.sample_d[mwtb_pkg::SampleW-1], in_item_i.sample_d};
    cls.tbl_idx      = in_item_i.table_index;
    cls.tbl_val      = in_item_i.table_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_v_q <= 1'b0;
    end else if (take) begin
      front_v_q <= 1'b1;
    end else if (push_o) begin
      front_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      front_q <= cls;
    end
  end

endmodule

/* hw/rtl/mwtb_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwtb_fifo
// Short queue of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module mwtb_fifo #(
  parameter int unsigned Depth = mwtb_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mwtb_pkg::q_item_t data_i,
  input  logic              pop_i,
  output mwtb_pkg::q_item_t data_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mwtb_pkg::q_item_t entry_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hw/rtl/mwtb_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwtb_back
// Window, gamma lookup, tint and channel accumulation pipeline.
// ----------------------------------------------------------------------------
module mwtb_back #(
  parameter int unsigned Channels = mwtb_pkg::ChannelsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mwtb_pkg::cfg_t            cfg_i,
  input  logic                      empty_i,
  input  mwtb_pkg::q_item_t         head_i,
  output logic                      pop_o,
  output logic                      init_done_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mwtb_pkg::PixelW-1:0] out_word_o
);

  localparam int unsigned Depth = Channels * mwtb_pkg::Levels;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned FullW = mwtb_pkg::ChW + mwtb_pkg::LevelW;
  localparam int unsigned SW    = mwtb_pkg::SampleW;
  localparam int unsigned LW    = mwtb_pkg::LevelW;
  localparam int unsigned TW    = mwtb_pkg::TintW;
  localparam int unsigned SuW   = mwtb_pkg::SumW;
  localparam int unsigned PW    = LW + TW;

  // gamma memory and its power-up fill
  logic [LW-1:0]    gamma_mem [Depth];
  logic [AddrW-1:0] init_cnt_q;
  logic             init_done_q;

  logic             en;
  logic [4:0]       v_q;
  mwtb_pkg::ctrl_t  c1_q, c2_q, c3_q, c4_q, c5_q;
  logic [LW-1:0]    ti2_q, tv2_q, ti3_q, tv3_q, ti1_q, tv1_q;

  logic signed [SW-1:0] s1_q;
  logic [SW-1:0]        d2_q;
  logic [SW-1:0]        ip3_q;
  logic [LW-1:0]        rd_q;
  logic [TW-1:0]        col_r5_q, col_g5_q, col_b5_q;
  logic [SuW-1:0]       sum_r_q, sum_g_q, sum_b_q;
  logic                 out_v_q;
  logic [mwtb_pkg::PixelW-1:0] out_word_q;

  logic signed [SW+1:0] total;
  logic signed [SW-1:0] s_sel;
  mwtb_pkg::win_t       win2, win3;
  logic [SW:0]          diff;
  logic                 diff_pos;
  logic [2*SW-1:0]      prod;
  logic [LW-1:0]        grey;
  logic [FullW-1:0]     rd_full, wr_full;
  logic [AddrW-1:0]     rd_addr, wr_addr;
  logic                 tbl_we;
  logic [mwtb_pkg::TintPairW-1:0] pair;
  mwtb_pkg::tint_t      tint;
  logic [PW-1:0]        pr_r, pr_g, pr_b;
  logic [SuW:0]         add_r, add_g, add_b;
  logic [SuW-1:0]       nr, ng, nb;
  logic                 fire_out;

  assign en          = init_done_q & (~out_v_q | out_ready_i);
  assign pop_o       = en & ~empty_i;
  assign init_done_o = init_done_q;
  assign out_valid_o = out_v_q;
  assign out_word_o  = out_word_q;

  // stage 1: neighbourhood average or first sample
  always_comb begin
    total = {head_i.sum_ab[SW], head_i.sum_ab} + {head_i.sum_cd[SW], head_i.sum_cd};
    s_sel = cfg_i.avg ? total[SW+1:2] : head_i.sample_a;
  end

  // stage 2: subtract window low, keep only positive distances
  always_comb begin
    win2     = cfg_i.win[c1_q.channel];
    diff     = {s1_q[SW-1], s1_q} - {win2.lo[SW-1], win2.lo};
    diff_pos = ~diff[SW] & (diff[SW-1:0] != '0);
  end

  // stage 3: scale multiply, integer part of the Q32.32 product
  always_comb begin
    win3 = cfg_i.win[c2_q.channel];
    prod = (2*SW)'(d2_q) * (2*SW)'(win3.scale);
  end

  // stage 4: clamp to a grey level, gamma read or table write
  always_comb begin
    grey    = (ip3_q >= SW'(mwtb_pkg::GreyMax)) ? mwtb_pkg::GreyMax : ip3_q[LW-1:0];
    rd_full = {c3_q.channel, grey};
    wr_full = {c3_q.channel, ti3_q};
    rd_addr = rd_full[AddrW-1:0];
    wr_addr = wr_full[AddrW-1:0];
    tbl_we  = en & v_q[2] & (c3_q.op == mwtb_pkg::OP_TABLE) & c3_q.ch_ok;
  end

  // stage 5: tint the corrected grey level
  always_comb begin
    pair = c4_q.channel[1] ? cfg_i.tint_hi : cfg_i.tint_lo;
    tint = mwtb_pkg::tint_t'(c4_q.channel[0] ? pair[2*mwtb_pkg::TintSetW-1:mwtb_pkg::TintSetW]
                                             : pair[mwtb_pkg::TintSetW-1:0]);
    pr_r = PW'(rd_q) * PW'(tint.red);
    pr_g = PW'(rd_q) * PW'(tint.green);
    pr_b = PW'(rd_q) * PW'(tint.blue);
  end

  // accumulate with saturation, emit on the pixel's last channel
  always_comb begin
    add_r = (SuW+1)'(sum_r_q) + (SuW+1)'(col_r5_q);
    add_g = (SuW+1)'(sum_g_q) + (SuW+1)'(col_g5_q);
    add_b = (SuW+1)'(sum_b_q) + (SuW+1)'(col_b5_q);
    nr = sum_r_q;
    ng = sum_g_q;
    nb = sum_b_q;
    if (c5_q.ch_ok) begin
      nr = (add_r > (SuW+1)'(mwtb_pkg::SumMax)) ? mwtb_pkg::SumMax : add_r[SuW-1:0];
      ng = (add_g > (SuW+1)'(mwtb_pkg::SumMax)) ? mwtb_pkg::SumMax : add_g[SuW-1:0];
      nb = (add_b > (SuW+1)'(mwtb_pkg::SumMax)) ? mwtb_pkg::SumMax : add_b[SuW-1:0];
    end
    fire_out = en & v_q[4] & (c5_q.op == mwtb_pkg::OP_SAMPLE) & c5_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q  <= '0;
      init_done_q <= 1'b0;
      v_q         <= '0;
      sum_r_q     <= '0;
      sum_g_q     <= '0;
      sum_b_q     <= '0;
      out_v_q     <= 1'b0;
    end else begin
      if (!init_done_q) begin
        init_cnt_q <= init_cnt_q + 1'b1;
        if (init_cnt_q == AddrW'(Depth - 1)) begin
          init_done_q <= 1'b1;
        end
      end
      if (en) begin
        v_q <= {v_q[3:0], ~empty_i};
        if (v_q[4] && c5_q.op == mwtb_pkg::OP_SAMPLE) begin
          if (c5_q.last) begin
            sum_r_q <= '0;
            sum_g_q <= '0;
            sum_b_q <= '0;
          end else begin
            sum_r_q <= nr;
            sum_g_q <= ng;
            sum_b_q <= nb;
          end
        end
      end
      if (fire_out) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q     <= head_i.ctrl;
      s1_q     <= s_sel;
      ti1_q    <= head_i.tbl_idx;
      tv1_q    <= head_i.tbl_val;
      c2_q     <= c1_q;
      d2_q     <= diff_pos ? diff[SW-1:0] : '0;
      ti2_q    <= ti1_q;
      tv2_q    <= tv1_q;
      c3_q     <= c2_q;
      ip3_q    <= prod[2*SW-1:SW];
      ti3_q    <= ti2_q;
      tv3_q    <= tv2_q;
      c4_q     <= c3_q;
      c5_q     <= c4_q;
      col_r5_q <= pr_r[PW-1:LW];
      col_g5_q <= pr_g[PW-1:LW];
      col_b5_q <= pr_b[PW-1:LW];
    end
    if (fire_out) begin
      out_word_q <= {mwtb_pkg::AlphaOn,
                     (nr > SuW'(mwtb_pkg::GreyMax)) ? mwtb_pkg::GreyMax : nr[LW-1:0],
                     (ng > SuW'(mwtb_pkg::GreyMax)) ? mwtb_pkg::GreyMax : ng[LW-1:0],
                     (nb > SuW'(mwtb_pkg::GreyMax)) ? mwtb_pkg::GreyMax : nb[LW-1:0]};
    end
  end

  // table writes and reads happen at the same stage, so program order holds
  always_ff @(posedge clk_i) begin
    if (!init_done_q) begin
      gamma_mem[init_cnt_q] <= init_cnt_q[LW-1:0];
    end else if (tbl_we) begin
      gamma_mem[wr_addr] <= tv3_q;
    end
    if (en) begin
      rd_q <= gamma_mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_idle_during_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done_q |-> (v_q == '0 && !out_v_q))
    else $error("pipeline active during gamma fill");

  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(fire_out))
    else $error("pixel emitted without a last-channel sample");

  a_sums_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_out |=> (sum_r_q == '0 && sum_g_q == '0 && sum_b_q == '0))
    else $error("colour sums not cleared after pixel");
`endif

endmodule

/* hw/rtl/multichannel_window_tint_blend.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_window_tint_blend
// Windowed, gamma corrected, tinted additive composite of channel samples.
// ----------------------------------------------------------------------------
// path: front register, queue, back stages, then the pixel_word register
// throughput: one request per cycle while no pixel waits on out_o.ready, with
// separate gamma read and write ports and a one-stage window multiplier
// reset: after rst_ni the gamma memory of every channel is filled with an
// identity ramp, with in_i.ready low; config writes are taken meanwhile
module multichannel_window_tint_blend #(
  parameter int unsigned CHANNELS = mwtb_pkg::ChannelsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mwtb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mwtb_pkg::CfgW-1:0]     cfg_data_i,
  mwtb_in_if.sink                       in_i,
  mwtb_out_if.source                    out_o
);

  mwtb_pkg::cfg_t    cfg_q;
  mwtb_pkg::q_item_t push_item, head_item;
  logic              push, pop, full, empty, init_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mwtb_pkg::WinCount; i++) begin
        cfg_q.win[i] <= mwtb_pkg::win_t'(mwtb_pkg::WinRst);
      end
      cfg_q.tint_lo <= mwtb_pkg::TintRst;
      cfg_q.tint_hi <= mwtb_pkg::TintRst;
      cfg_q.avg     <= 1'b0;
    end else if (cfg_we_i) begin
      case (mwtb_pkg::cfg_idx_e'(cfg_idx_i))
        mwtb_pkg::CFG_WIN0:    cfg_q.win[0]  <= mwtb_pkg::win_t'(cfg_data_i);
        mwtb_pkg::CFG_WIN1:    cfg_q.win[1]  <= mwtb_pkg::win_t'(cfg_data_i);
        mwtb_pkg::CFG_WIN2:    cfg_q.win[2]  <= mwtb_pkg::win_t'(cfg_data_i);
        mwtb_pkg::CFG_WIN3:    cfg_q.win[3]  <= mwtb_pkg::win_t'(cfg_data_i);
        mwtb_pkg::CFG_TINT_LO: cfg_q.tint_lo <= cfg_data_i[mwtb_pkg::TintPairW-1:0];
        mwtb_pkg::CFG_TINT_HI: cfg_q.tint_hi <= cfg_data_i[mwtb_pkg::TintPairW-1:0];
        mwtb_pkg::CFG_AVG:     cfg_q.avg     <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  mwtb_front #(
    .Channels (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_done_i (init_done),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_item_i   (in_i.data),
    .full_i      (full),
    .push_o      (push),
    .q_item_o    (push_item)
  );

  mwtb_fifo #(
    .Depth (mwtb_pkg::QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .pop_i   (pop),
    .data_o  (head_item),
    .full_o  (full),
    .empty_o (empty)
  );

  mwtb_back #(
    .Channels (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .head_i      (head_item),
    .pop_o       (pop),
    .init_done_o (init_done),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_o.data.pixel_word)
  );

endmodule

/* tb/sv/multichannel_window_tint_blend_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_window_tint_blend_tb
// Self-checking bench for the window/tint blend. A driver feeds sample and
// gamma table requests from a queue and a monitor drains pixel words, both
// with random stalls. Every accepted request goes through a behavioral model
// of window, gamma, tint and colour sums; each pixel word is checked in order.
// ----------------------------------------------------------------------------
module multichannel_window_tint_blend_tb;

  localparam int unsigned NumCh        = mwtb_pkg::ChannelsDef;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned TimeoutNs    = 5_000_000;

  typedef enum int unsigned {
    CFG_MIXED,
    CFG_ALL_MAX,
    CFG_ALL_MIN
  } cfg_style_e;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [mwtb_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [mwtb_pkg::CfgW-1:0]    cfg_data_i;

  mwtb_in_if  req_if ();
  mwtb_out_if pix_if ();

  multichannel_window_tint_blend #(
    .CHANNELS(NumCh)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (req_if),
    .out_o     (pix_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // model state and configuration
  logic signed [mwtb_pkg::SampleW-1:0] win_lo [NumCh];
  logic [mwtb_pkg::SampleW-1:0]        win_scale [NumCh];
  logic [mwtb_pkg::TintPairW-1:0]      tint_lo;
  logic [mwtb_pkg::TintPairW-1:0]      tint_hi;
  logic                                avg_on;
  int                                  red_acc, green_acc, blue_acc;
  logic [mwtb_pkg::LevelW-1:0]         gamma_lut [NumCh][mwtb_pkg::Levels];

  mwtb_pkg::in_item_t          req_queue [$];
  logic [mwtb_pkg::PixelW-1:0] pixel_expect [$];
  longint                      stim_range [NumCh];
  int unsigned                 stim_count;
  int unsigned                 mismatch_count = 0;

  int unsigned req_taken = 0, req_handled = 0;
  int unsigned pix_taken = 0, pix_handled = 0;
  logic        req_valid_nx;
  logic        pix_ready_nx;
  int unsigned req_gap = 0, pix_gap = 0;
  int unsigned req_run_left = 0, pix_run_left = 0;
  bit          req_run_fast, pix_run_fast;
  bit          hold_go = 1'b0;
  bit          hold_on;

  function automatic int sum_sat(int acc, int v);
    return (acc + v > int'(mwtb_pkg::SumMax)) ? int'(mwtb_pkg::SumMax) : acc + v;
  endfunction

  function automatic logic [mwtb_pkg::LevelW-1:0] clamp_level(int v);
    return (v > 255) ? mwtb_pkg::GreyMax : v[7:0];
  endfunction

  task automatic model_reset();
    for (int unsigned c = 0; c < NumCh; c++) begin
      win_lo[c]     = mwtb_pkg::WinRst[63:32];
      win_scale[c]  = mwtb_pkg::WinRst[31:0];
      stim_range[c] = 64'd65536;
    end
    tint_lo = mwtb_pkg::TintRst;
    tint_hi = mwtb_pkg::TintRst;
    avg_on  = 1'b0;
  endtask

  // gamma ramp and colour sums, as the block holds them after reset
  function automatic void state_reset();
    for (int unsigned c = 0; c < NumCh; c++) begin
      for (int i = 0; i < mwtb_pkg::Levels; i++) gamma_lut[c][i] = 8'(i);
    end
    red_acc   = 0;
    green_acc = 0;
    blue_acc  = 0;
  endfunction

  // table write, or window, gamma, tint and accumulate, for one accepted request
  function automatic void blend_request(mwtb_pkg::in_item_t rq);
    int unsigned                    ch;
    longint                         s, diff;
    logic [63:0]                    du, prod;
    logic [31:0]                    ip;
    logic [mwtb_pkg::LevelW-1:0]    grey;
    logic [mwtb_pkg::TintPairW-1:0] tints;
    logic [mwtb_pkg::TintW-1:0]     tr, tg, tb;
    logic [mwtb_pkg::PixelW-1:0]    word;
    ch = 32'(rq.channel);
    if (rq.opcode == mwtb_pkg::OP_TABLE) begin
      if (ch < NumCh) gamma_lut[ch][rq.table_index] = rq.table_value;
      return;
    end
    if (ch < NumCh) begin
      if (avg_on) begin
        s = (longint'(rq.sample_a) + longint'(rq.sample_b) +
             longint'(rq.sample_c) + longint'(rq.sample_d)) >>> 2;
      end else begin
        s = longint'(rq.sample_a);
      end
      diff = s - longint'(win_lo[ch]);
      grey = '0;
      if (diff > 0) begin
        du   = diff;
        prod = du * {32'd0, win_scale[ch]};
        ip   = prod[63:32];
        grey = (ip >= 32'd255) ? mwtb_pkg::GreyMax : ip[7:0];
      end
      grey  = gamma_lut[ch][grey];
      tints = (ch < 2) ? tint_lo : tint_hi;
      if (ch[0]) tints = tints >> mwtb_pkg::TintSetW;
      tr = tints[8:0];
      tg = tints[17:9];
      tb = tints[26:18];
      red_acc   = sum_sat(red_acc, (int'(grey) * int'(tr)) >> 8);
      green_acc = sum_sat(green_acc, (int'(grey) * int'(tg)) >> 8);
      blue_acc  = sum_sat(blue_acc, (int'(grey) * int'(tb)) >> 8);
    end
    if (rq.last_channel) begin
      word = {mwtb_pkg::AlphaOn, clamp_level(red_acc), clamp_level(green_acc),
              clamp_level(blue_acc)};
      pixel_expect = {pixel_expect, word};
      red_acc   = 0;
      green_acc = 0;
      blue_acc  = 0;
    end
  endfunction

  // stall length per item, with runs of back-to-back traffic
  function automatic int unsigned draw_gap(inout int unsigned run_left, inout bit run_fast);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 64);
      run_fast = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return run_fast ? 0 : $urandom_range(0, 13);
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
    end else begin
      req_valid_nx = req_if.valid;
      if (req_taken != req_handled) begin
        req_handled  = req_taken;
        req_valid_nx = 1'b0;
      end
      if (!req_valid_nx) begin
        if (req_gap != 0) begin
          req_gap--;
        end else if (req_queue.size() != 0) begin
          req_if.data <= req_queue.pop_front();
          req_valid_nx = 1'b1;
          req_gap      = draw_gap(req_run_left, req_run_fast);
        end
      end
      req_if.valid <= req_valid_nx;
    end
  end

  // pixel receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pix_if.ready <= 1'b0;
    end else begin
      pix_ready_nx = pix_if.ready;
      if (pix_taken != pix_handled) begin
        pix_handled  = pix_taken;
        pix_ready_nx = 1'b0;
        pix_gap      = draw_gap(pix_run_left, pix_run_fast);
      end
      if (hold_on) begin
        pix_ready_nx = 1'b0;
      end else if (!pix_ready_nx) begin
        if (pix_gap != 0) pix_gap--;
        else pix_ready_nx = 1'b1;
      end
      pix_if.ready <= pix_ready_nx;
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    hold_on = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    hold_on = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on = 1'b0;
  end

  // handshakes at the rising edge
  always @(posedge clk_i) begin
    logic [mwtb_pkg::PixelW-1:0] want;
    if (!rst_ni) begin
      state_reset();
    end else begin
      if (req_if.valid && req_if.ready) begin
        blend_request(req_if.data);
        req_taken++;
      end
      if (pix_if.valid && pix_if.ready) begin
        pix_taken++;
        if (pixel_expect.size() == 0) begin
          $display("%0t: pixel_word expected none, got %h", $time, pix_if.data.pixel_word);
          mismatch_count++;
        end else begin
          want = pixel_expect.pop_front();
          if (pix_if.data.pixel_word !== want) begin
            $display("%0t: pixel_word expected %h, got %h", $time, want,
                     pix_if.data.pixel_word);
            mismatch_count++;
          end
        end
      end
    end
  end

  task automatic write_reg(mwtb_pkg::cfg_idx_e idx, logic [mwtb_pkg::CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      mwtb_pkg::CFG_WIN0, mwtb_pkg::CFG_WIN1, mwtb_pkg::CFG_WIN2, mwtb_pkg::CFG_WIN3: begin
        win_lo[int'(idx)]    = val[63:32];
        win_scale[int'(idx)] = val[31:0];
      end
      mwtb_pkg::CFG_TINT_LO: tint_lo = val[mwtb_pkg::TintPairW-1:0];
      mwtb_pkg::CFG_TINT_HI: tint_hi = val[mwtb_pkg::TintPairW-1:0];
      mwtb_pkg::CFG_AVG:     avg_on  = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (req_queue.size() != 0 || req_if.valid || pixel_expect.size() != 0);
    // requests without a pixel may still be in the pipe
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic mwtb_pkg::in_item_t rand_item();
    mwtb_pkg::in_item_t it;
    it.opcode       = 1'($urandom_range(0, 1));
    it.channel      = 2'($urandom_range(0, 3));
    it.sample_a     = $urandom;
    it.sample_b     = $urandom;
    it.sample_c     = $urandom;
    it.sample_d     = $urandom;
    it.last_channel = 1'($urandom_range(0, 1));
    it.table_index  = 8'($urandom_range(0, 255));
    it.table_value  = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic push_sample(int unsigned ch, logic [31:0] a, logic [31:0] b,
                             logic [31:0] c, logic [31:0] d, logic last);
    mwtb_pkg::in_item_t it;
    it              = rand_item();
    it.opcode       = mwtb_pkg::OP_SAMPLE;
    it.channel      = 2'(ch);
    it.sample_a     = a;
    it.sample_b     = b;
    it.sample_c     = c;
    it.sample_d     = d;
    it.last_channel = last;
    req_queue = {req_queue, it};
    stim_count++;
  endtask

  task automatic push_table(int unsigned ch, int unsigned idx, int unsigned val);
    mwtb_pkg::in_item_t it;
    it             = rand_item();
    it.opcode      = mwtb_pkg::OP_TABLE;
    it.channel     = 2'(ch);
    it.table_index = 8'(idx);
    it.table_value = 8'(val);
    req_queue = {req_queue, it};
    stim_count++;
  endtask

  // sample around the channel's window, a little past both ends
  function automatic logic [31:0] near_window(int unsigned ch);
    longint r, v;
    r = stim_range[ch];
    if (r == 0 || $urandom_range(0, 7) == 0) return $urandom;
    v = longint'(win_lo[ch]) - r / 8 + longint'($urandom_range(0, 32'(r + r / 4)));
    return v[31:0];
  endfunction

  function automatic logic [31:0] jitter(int unsigned ch, logic [31:0] a);
    longint r, v;
    r = stim_range[ch];
    if (r == 0 || $urandom_range(0, 7) == 0) return $urandom;
    v = longint'($signed(a)) + longint'($urandom_range(0, 32'(r / 2))) - r / 4;
    return v[31:0];
  endfunction

  task automatic setup_phase(cfg_style_e style);
    logic [mwtb_pkg::CfgW-1:0] w, scl;
    logic signed [31:0]        lo;
    int unsigned               rng;
    for (int unsigned ch = 0; ch < NumCh; ch++) begin
      stim_range[ch] = 0;
      w = {$urandom, $urandom};
      case (style)
        CFG_ALL_MAX: w = {32'h8000_0000, 32'hFFFF_FFFF};
        CFG_ALL_MIN: w = {32'h7FFF_FFFF, 32'h0000_0000};
        default: if ($urandom_range(0, 4) != 0) begin
          rng = $urandom_range(1 << 12, 1 << 26);
          lo  = $signed($urandom) >>> 2;
          scl = (64'd255 << 32) / rng;
          w   = {lo, scl[31:0]};
          stim_range[ch] = longint'(rng);
        end
      endcase
      write_reg(mwtb_pkg::cfg_idx_e'(ch), w);
    end
    for (int unsigned p = 0; p < 2; p++) begin
      w = {$urandom, $urandom};
      case (style)
        CFG_ALL_MAX: w[mwtb_pkg::TintPairW-1:0] = {6{9'd511}};
        CFG_ALL_MIN: w[mwtb_pkg::TintPairW-1:0] = '0;
        default: begin
          for (int unsigned t = 0; t < 6; t++) begin
            w[t*mwtb_pkg::TintW +: mwtb_pkg::TintW] = ($urandom_range(0, 3) == 0) ?
                9'($urandom_range(257, 511)) : 9'($urandom_range(0, 256));
          end
        end
      endcase
      write_reg((p == 0) ? mwtb_pkg::CFG_TINT_LO : mwtb_pkg::CFG_TINT_HI, w);
    end
    w = {$urandom, $urandom};
    case (style)
      CFG_ALL_MAX: w[0] = 1'b1;
      CFG_ALL_MIN: w[0] = 1'b0;
      default:     w[0] = 1'($urandom_range(0, 1));
    endcase
    write_reg(mwtb_pkg::CFG_AVG, w);
  endtask

  task automatic random_phase(cfg_style_e style, int unsigned n_items, bit squeeze);
    int unsigned start, nch, tch, base, j, tmp;
    int unsigned order [4];
    bit          broken;
    logic [31:0] a;
    setup_phase(style);
    if (squeeze) hold_go = 1'b1;
    start = stim_count;
    if ($urandom_range(0, 1) == 1) begin
      // dense load of a slice of one gamma table
      tch  = $urandom_range(0, 3);
      base = $urandom_range(0, 224);
      for (int unsigned k = 0; k < 32; k++) push_table(tch, base + k, $urandom_range(0, 255));
    end
    while (stim_count - start < n_items) begin
      if ($urandom_range(0, 15) == 0) begin
        push_table($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        nch = (squeeze && $urandom_range(0, 3) != 0) ? 1 : $urandom_range(1, 4);
        order = '{0, 1, 2, 3};
        for (int unsigned k = 3; k > 0; k--) begin
          j        = $urandom_range(0, k);
          tmp      = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        broken = ($urandom_range(0, 15) == 0);
        for (int unsigned k = 0; k < nch; k++) begin
          tch = broken ? $urandom_range(0, 3) : order[k];
          a   = near_window(tch);
          push_sample(tch, a, jitter(tch, a), jitter(tch, a), jitter(tch, a),
                      broken ? 1'($urandom_range(0, 1)) : (k == nch - 1));
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    #(TimeoutNs);
    $display("** multichannel_window_tint_blend: FAILED **");
    $finish;
  end

  initial begin
    cfg_we_i     = 1'b0;
    cfg_idx_i    = mwtb_pkg::CFG_WIN0;
    cfg_data_i   = '0;
    rst_ni       = 1'b0;
    stim_count   = 0;
    model_reset();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: lo 0, scale 255/65536 in Q0.32, unit tints, single sample
    push_sample(0, 32'h0000_0000, $urandom, $urandom, $urandom, 1'b1);
    push_sample(0, 32'h7FFF_FFFF, $urandom, $urandom, $urandom, 1'b1);
    push_sample(1, 32'h8000_0000, $urandom, $urandom, $urandom, 1'b1);
    push_sample(2, 32'h0000_8000, $urandom, $urandom, $urandom, 1'b1);
    push_sample(3, 32'h0001_0000, $urandom, $urandom, $urandom, 1'b1);
    for (int unsigned c = 0; c < NumCh; c++) begin
      push_sample(c, 32'h0000_4000, $urandom, $urandom, $urandom, c == NumCh - 1);
    end
    push_table(0, 0, 8'hFF);
    push_table(3, 255, 8'h00);
    push_sample(0, 32'h8000_0000, $urandom, $urandom, $urandom, 1'b1);
    push_sample(3, 32'h7FFF_FFFF, $urandom, $urandom, $urandom, 1'b1);
    wait_idle();

    // edge windows, tints above 256 and zero, averaging on
    write_reg(mwtb_pkg::CFG_WIN0, {32'hFFFF_FFFF, 32'hFFFF_FFFF});
    write_reg(mwtb_pkg::CFG_WIN1, {32'h8000_0000, 32'hFFFF_FFFF});
    write_reg(mwtb_pkg::CFG_WIN2, {32'h7FFF_FFFF, 32'h0000_0001});
    write_reg(mwtb_pkg::CFG_WIN3, {32'h0000_0000, 32'h0000_0000});
    write_reg(mwtb_pkg::CFG_TINT_LO,
              {10'($urandom), 9'd511, 9'd511, 9'd511, 9'd256, 9'd0, 9'd511});
    write_reg(mwtb_pkg::CFG_TINT_HI, {10'($urandom), 9'd1, 9'd256, 9'd511, 27'd0});
    write_reg(mwtb_pkg::CFG_AVG, {$urandom, $urandom} | 64'd1);
    for (int unsigned c = 0; c < NumCh; c++) stim_range[c] = 0;
    push_sample(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    push_sample(0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b1);
    push_sample(0, 32'h0, 32'h0, 32'h0, 32'h4, 1'b1);
    push_sample(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    push_sample(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    for (int unsigned k = 0; k < 3; k++) begin
      push_sample(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, k == 2);
    end
    push_sample(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    push_sample(3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    for (int unsigned c = 0; c < NumCh; c++) begin
      push_sample(c, $urandom, $urandom, $urandom, $urandom, c == NumCh - 1);
    end
    wait_idle();

    random_phase(CFG_MIXED, 230, 1'b0);
    random_phase(CFG_MIXED, 230, 1'b0);
    random_phase(CFG_MIXED, 230, 1'b1);
    random_phase(CFG_ALL_MAX, 60, 1'b0);
    random_phase(CFG_MIXED, 230, 1'b0);
    random_phase(CFG_ALL_MIN, 60, 1'b0);
    random_phase(CFG_MIXED, 230, 1'b0);
    random_phase(CFG_MIXED, 230, 1'b0);

    if (mismatch_count == 0) begin
      $display("** multichannel_window_tint_blend: PASSED **");
    end else begin
      $display("** multichannel_window_tint_blend: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mwtb_pkg.sv
hw/rtl/mwtb_if.sv
hw/rtl/mwtb_front.sv
hw/rtl/mwtb_fifo.sv
hw/rtl/mwtb_back.sv
hw/rtl/multichannel_window_tint_blend.sv
tb/sv/multichannel_window_tint_blend_tb.sv
